// ===== hw/rtl/dhpi_pkg.sv =====
`timescale 1ns / 1ps

package dhpi_pkg;

    localparam int KEY_W     = 8;
    localparam int ATTEMPT_W = 16;
    localparam int SLOT_W    = 16;
    localparam int PRIME_W   = 16;
    localparam int TSIZE_W   = 17;
    localparam int CFG_IDX_W = 2;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRIME_A    = 2'd0,
        CFG_PRIME_B    = 2'd1,
        CFG_TABLE_SIZE = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic accept;     // load the byte and start both reductions
        logic upd_acc;    // take the remainders into the accumulators
        logic fin_start;  // start the probe step reduction
        logic out_load;   // form the slot and load the output register
    } dhpi_cmd_t;

    typedef struct packed {
        logic red_done;   // both remainder units idle
        logic last;       // byte in flight ends the key
        logic out_free;   // output register can take a result
    } dhpi_status_t;

endpackage

// ===== hw/rtl/double_hash_probe_index_unit.sv =====
`timescale 1ns / 1ps
// one key byte per transfer, reduced by a bit-serial remainder unit of ACC_W+17 steps
// (at most 34); the next byte is taken only after both remainders reach the accumulators
// the final byte adds a second pass for the probe step, and its result goes to the output
// register before the next byte is taken
// a result waits in an output register while the next key is taken in
// synchronous active-low reset clears the accumulators and restores 151, 163 and 1024
module double_hash_probe_index_unit #(
    parameter int INDEX_BITS = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [dhpi_pkg::KEY_W-1:0]             s_key_byte,
    input  logic                                   s_last_byte,
    input  logic [dhpi_pkg::ATTEMPT_W-1:0]         s_attempt,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [dhpi_pkg::SLOT_W-1:0]            m_slot_index,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [dhpi_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dhpi_pkg::TSIZE_W-1:0]           cfg_data
);

    import dhpi_pkg::*;

    // modulus never exceeds the smaller of 2^INDEX_BITS and the table size range
    localparam int ACC_W = (INDEX_BITS < TSIZE_W) ? INDEX_BITS : TSIZE_W;
    localparam int MOD_W = (INDEX_BITS < TSIZE_W) ? INDEX_BITS + 1 : TSIZE_W;
    localparam int DIV_W = ACC_W + 17;
    localparam logic [32:0] MAX_MOD = 33'd1 << INDEX_BITS;

    logic [PRIME_W-1:0] prime_a_reg, prime_a_next;
    logic [PRIME_W-1:0] prime_b_reg, prime_b_next;
    logic [TSIZE_W-1:0] table_size_reg, table_size_next;
    logic [32:0]        ts_wide;
    logic [32:0]        mod_wide;
    logic [MOD_W-1:0]   modulus;

    dhpi_cmd_t    cmd;
    dhpi_status_t status;

    assign cfg_ready = 1'b1;

    always_comb begin
        prime_a_next    = prime_a_reg;
        prime_b_next    = prime_b_reg;
        table_size_next = table_size_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_PRIME_A:    prime_a_next    = cfg_data[PRIME_W-1:0];
                CFG_PRIME_B:    prime_b_next    = cfg_data[PRIME_W-1:0];
                CFG_TABLE_SIZE: table_size_next = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prime_a_reg    <= PRIME_W'(151);
            prime_b_reg    <= PRIME_W'(163);
            table_size_reg <= TSIZE_W'(1024);
        end else begin
            prime_a_reg    <= prime_a_next;
            prime_b_reg    <= prime_b_next;
            table_size_reg <= table_size_next;
        end
    end

    // zero size acts as one slot, oversized saturates at 2^INDEX_BITS
    assign ts_wide  = 33'(table_size_reg);
    assign mod_wide = (table_size_reg == '0) ? 33'd1 :
                      (ts_wide > MAX_MOD)    ? MAX_MOD : ts_wide;
    assign modulus  = mod_wide[MOD_W-1:0];

    dhpi_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    dhpi_datapath #(
        .ACC_W (ACC_W),
        .MOD_W (MOD_W),
        .DIV_W (DIV_W)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_key_byte   (s_key_byte),
        .s_last_byte  (s_last_byte),
        .s_attempt    (s_attempt),
        .prime_a      (prime_a_reg),
        .prime_b      (prime_b_reg),
        .modulus      (modulus),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_slot_index (m_slot_index)
    );

endmodule

// ===== hw/rtl/dhpi_mod_unit.sv =====
`timescale 1ns / 1ps

module dhpi_mod_unit #(
    parameter int DIV_W = 33,
    parameter int MOD_W = 17,
    parameter int OUT_W = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [MOD_W-1:0] modulus,
    output logic             busy,
    output logic [OUT_W-1:0] rem
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] div_reg, div_next;
    logic [MOD_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MOD_W:0]   trial;
    logic [MOD_W:0]   diff;

    // restoring remainder, one dividend bit per cycle
    always_comb begin
        trial    = {rem_reg, div_reg[DIV_W-1]};
        diff     = trial - {1'b0, modulus};
        div_next = div_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        if (start) begin
            div_next = dividend;
            rem_next = '0;
            cnt_next = CNT_W'(DIV_W);
        end else if (cnt_reg != '0) begin
            div_next = {div_reg[DIV_W-2:0], 1'b0};
            rem_next = (trial >= {1'b0, modulus}) ? diff[MOD_W-1:0] : trial[MOD_W-1:0];
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign busy = (cnt_reg != '0);
    assign rem  = rem_reg[OUT_W-1:0];

endmodule

// ===== hw/rtl/dhpi_datapath.sv =====
`timescale 1ns / 1ps

module dhpi_datapath #(
    parameter int ACC_W = 16,
    parameter int MOD_W = 17,
    parameter int DIV_W = 33
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  dhpi_pkg::dhpi_cmd_t               cmd,
    output dhpi_pkg::dhpi_status_t            status,
    input  logic [dhpi_pkg::KEY_W-1:0]        s_key_byte,
    input  logic                              s_last_byte,
    input  logic [dhpi_pkg::ATTEMPT_W-1:0]    s_attempt,
    input  logic [dhpi_pkg::PRIME_W-1:0]      prime_a,
    input  logic [dhpi_pkg::PRIME_W-1:0]      prime_b,
    input  logic [MOD_W-1:0]                  modulus,
    input  logic                              m_ready,
    output logic                              m_valid,
    output logic [dhpi_pkg::SLOT_W-1:0]       m_slot_index
);

    import dhpi_pkg::*;

    localparam int SUM_W = ACC_W + 1;

    logic [ACC_W-1:0]     acc_a_reg, acc_a_next;
    logic [ACC_W-1:0]     acc_b_reg, acc_b_next;
    logic                 last_reg;
    logic [ATTEMPT_W-1:0] attempt_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [SLOT_W-1:0]    slot_reg;

    logic [ACC_W+15:0]    mul_a, mul_b;
    logic [DIV_W-1:0]     byte_prod_a, byte_prod_b;
    logic [ACC_W:0]       step_b;
    logic [DIV_W-1:0]     fin_prod;
    logic [DIV_W-1:0]     dividend_a;
    logic                 busy_a, busy_b;
    logic [ACC_W-1:0]     rem_a, rem_b;
    logic [SUM_W-1:0]     slot_sum, slot_diff, mod_ext;
    logic [ACC_W-1:0]     slot;
    logic [31:0]          slot_ext;

    // horner step: acc * prime + byte, reduced by the units below
    assign mul_a       = (ACC_W+16)'(acc_a_reg) * (ACC_W+16)'(prime_a);
    assign mul_b       = (ACC_W+16)'(acc_b_reg) * (ACC_W+16)'(prime_b);
    assign byte_prod_a = DIV_W'(mul_a) + DIV_W'(s_key_byte);
    assign byte_prod_b = DIV_W'(mul_b) + DIV_W'(s_key_byte);

    // probe step attempt * (hash_b + 1)
    assign step_b     = {1'b0, acc_b_reg} + {{ACC_W{1'b0}}, 1'b1};
    assign fin_prod   = DIV_W'(attempt_reg) * DIV_W'(step_b);
    assign dividend_a = cmd.fin_start ? fin_prod : byte_prod_a;

    dhpi_mod_unit #(
        .DIV_W (DIV_W),
        .MOD_W (MOD_W),
        .OUT_W (ACC_W)
    ) u_mod_a (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.accept | cmd.fin_start),
        .dividend (dividend_a),
        .modulus  (modulus),
        .busy     (busy_a),
        .rem      (rem_a)
    );

    dhpi_mod_unit #(
        .DIV_W (DIV_W),
        .MOD_W (MOD_W),
        .OUT_W (ACC_W)
    ) u_mod_b (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.accept),
        .dividend (byte_prod_b),
        .modulus  (modulus),
        .busy     (busy_b),
        .rem      (rem_b)
    );

    // hash_a + step term, both below the modulus: one conditional subtract
    assign mod_ext   = SUM_W'(modulus);
    assign slot_sum  = {1'b0, acc_a_reg} + {1'b0, rem_a};
    assign slot_diff = slot_sum - mod_ext;
    assign slot      = (slot_sum >= mod_ext) ? slot_diff[ACC_W-1:0] : slot_sum[ACC_W-1:0];
    assign slot_ext  = 32'(slot);

    always_comb begin
        acc_a_next   = acc_a_reg;
        acc_b_next   = acc_b_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.upd_acc) begin
            acc_a_next = rem_a;
            acc_b_next = rem_b;
        end
        if (cmd.out_load) begin
            acc_a_next   = '0;
            acc_b_next   = '0;
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_a_reg   <= '0;
            acc_b_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_a_reg   <= acc_a_next;
            acc_b_reg   <= acc_b_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            last_reg    <= s_last_byte;
            attempt_reg <= s_attempt;
        end
        if (cmd.out_load) begin
            slot_reg <= slot_ext[SLOT_W-1:0];
        end
    end

    assign status.red_done = !busy_a && !busy_b;
    assign status.last     = last_reg;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_slot_index = slot_reg;

`ifndef ASSERT_OFF
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept |=> !status.red_done)
        else $error("remainder units not started on transfer");

    a_acc_update: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.upd_acc && !cmd.out_load |=> acc_a_reg == $past(rem_a) && acc_b_reg == $past(rem_b))
        else $error("accumulators missed remainder update");

    a_out_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> m_valid_reg && acc_a_reg == '0 && acc_b_reg == '0)
        else $error("result load did not clear accumulators");
`endif

endmodule

// ===== hw/rtl/dhpi_ctrl.sv =====
`timescale 1ns / 1ps

module dhpi_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  dhpi_pkg::dhpi_status_t status,
    output dhpi_pkg::dhpi_cmd_t    cmd
);

    import dhpi_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RED  = 5'b00010,
        S_FIN  = 5'b00100,
        S_FRED = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = S_RED;
                end
            end
            S_RED: begin
                if (status.red_done) begin
                    cmd.upd_acc = 1'b1;
                    state_next  = status.last ? S_FIN : S_IDLE;
                end
            end
            S_FIN: begin
                cmd.fin_start = 1'b1;
                state_next    = S_FRED;
            end
            S_FRED: begin
                if (status.red_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // wait until the previous result has been taken
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== sim/double_hash_probe_index_unit_tb.sv =====
`timescale 1ns / 1ps

module double_hash_probe_index_unit_tb;
    import dhpi_pkg::*;

    localparam int IDX_BITS = 16;
    localparam longint unsigned MOD_CAP = 64'd1 << IDX_BITS;
    localparam int SETTLE_CYC = 2 * IDX_BITS + 60;
    localparam int LONG_HOLD = 400;
    localparam int CYCLE_LIMIT = 800000;
    localparam int RANDOM_BYTES = 550;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct {
        logic [KEY_W-1:0]     key;
        logic                 last;
        logic [ATTEMPT_W-1:0] attempt;
    } key_byte_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [KEY_W-1:0]     s_key_byte = '0;
    logic                 s_last_byte = 1'b0;
    logic [ATTEMPT_W-1:0] s_attempt = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [SLOT_W-1:0]    m_slot_index;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TSIZE_W-1:0]   cfg_data = '0;

    // predictor state
    logic [PRIME_W-1:0]   cur_prime_a = 16'd151;
    logic [PRIME_W-1:0]   cur_prime_b = 16'd163;
    logic [TSIZE_W-1:0]   cur_tsize = 17'd1024;
    logic [SLOT_W-1:0]    run_hash_a = '0;
    logic [SLOT_W-1:0]    run_hash_b = '0;

    key_byte_t            byte_q[$];
    logic [SLOT_W-1:0]    slot_expected_q[$];
    logic [SLOT_W-1:0]    exp_slot;

    bit                   s_offer = 1'b0;
    bit                   s_no_idle = 1'b0;
    bit                   m_no_idle = 1'b0;
    int                   s_gap = 0;
    int                   m_wait = 0;
    int                   hold_req = 0;
    int                   hold_done = 0;
    int                   err_cnt = 0;
    int                   bytes_sent = 0;
    int                   slots_seen = 0;
    int                   bytes_queued = 0;
    int                   reg_writes = 0;
    int                   cycles = 0;

    double_hash_probe_index_unit #(
        .INDEX_BITS(IDX_BITS)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_key_byte(s_key_byte),
        .s_last_byte(s_last_byte),
        .s_attempt(s_attempt),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_slot_index(m_slot_index),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // horner update of both hashes, slot formed on the final byte
    task automatic fold_key_byte(input logic [KEY_W-1:0] kb, input logic lb,
                                 input logic [ATTEMPT_W-1:0] att);
        longint unsigned m;
        longint unsigned slot;
        m = (cur_tsize == 0) ? 64'd1 : ((cur_tsize > MOD_CAP) ? MOD_CAP : 64'(cur_tsize));
        run_hash_a = 16'((((64'(run_hash_a) % m) * cur_prime_a) + kb) % m);
        run_hash_b = 16'((((64'(run_hash_b) % m) * cur_prime_b) + kb) % m);
        if (lb) begin
            slot = (64'(run_hash_a) + ((64'(att) * (64'(run_hash_b) + 64'd1)) % m)) % m;
            slot_expected_q.push_back(16'(slot));
            run_hash_a = '0;
            run_hash_b = '0;
        end
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_offer = 1'b0;
            s_gap = 0;
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                fold_key_byte(s_key_byte, s_last_byte, s_attempt);
                bytes_sent++;
                s_offer = 1'b0;
                s_gap = s_no_idle ? 0 : $urandom_range(0, 6);
            end
            if (!s_offer) begin
                if (s_gap > 0) begin
                    s_gap--;
                end else if (byte_q.size() != 0) begin
                    key_byte_t it;
                    it = byte_q.pop_front();
                    s_key_byte <= it.key;
                    s_last_byte <= it.last;
                    s_attempt <= it.attempt;
                    s_offer = 1'b1;
                end
            end
            s_valid <= s_offer;
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_wait = 0;
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (slot_expected_q.size() == 0) begin
                    err_cnt++;
                    $display("%0t: unexpected slot_index transfer, expected none, actual %0d",
                             $time, m_slot_index);
                end else begin
                    exp_slot = slot_expected_q.pop_front();
                    slots_seen++;
                    if (m_slot_index !== exp_slot) begin
                        err_cnt++;
                        $display("%0t: slot_index mismatch, expected %0d, actual %0d",
                                 $time, exp_slot, m_slot_index);
                    end
                end
                m_wait = m_no_idle ? 0 : $urandom_range(0, 6);
            end
            if (hold_done != hold_req) begin
                hold_done++;
                m_wait = LONG_HOLD;
            end
            if (m_wait > 0) begin
                m_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TSIZE_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        reg_writes++;
        case (idx)
            CFG_PRIME_A: begin
                cur_prime_a = val[PRIME_W-1:0];
            end
            CFG_PRIME_B: begin
                cur_prime_b = val[PRIME_W-1:0];
            end
            CFG_TABLE_SIZE: begin
                cur_tsize = val;
            end
            default: begin
            end
        endcase
    endtask

    task automatic drain_and_settle();
        while (byte_q.size() != 0 || s_offer || slot_expected_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic queue_byte(input logic [KEY_W-1:0] kb, input logic lb,
                              input logic [ATTEMPT_W-1:0] att);
        key_byte_t it;
        it.key = kb;
        it.last = lb;
        it.attempt = att;
        byte_q.push_back(it);
        bytes_queued++;
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [ATTEMPT_W-1:0] rand_attempt();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(1, 8));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int rand_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
    endfunction

    function automatic logic [TSIZE_W-1:0] rand_prime();
        case ($urandom_range(0, 5))
            0: return 17'($urandom);
            1: return 17'd2;
            2: return 17'd65535;
            default: return 17'($urandom_range(129, 65535));
        endcase
    endfunction

    function automatic logic [TSIZE_W-1:0] rand_tsize();
        case ($urandom_range(0, 7))
            0: return 17'd0;
            1: return 17'($urandom_range(1, 16));
            2: return 17'd65536;
            3: return 17'($urandom);
            default: return 17'($urandom_range(17, 65536));
        endcase
    endfunction

    task automatic queue_key(input int len, input bit finish);
        int i;
        for (i = 0; i < len; i++)
            queue_byte(rand_key(), finish && (i == len - 1), rand_attempt());
    endtask

    initial begin
        int i;
        int n;
        int rand_start;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings, single- and multi-byte keys and extreme bytes and attempts
        queue_byte(8'd0, 1'b1, 16'd0);
        queue_byte(8'd255, 1'b1, 16'hFFFF);
        for (i = 0; i < 5; i++)
            queue_byte(8'd255, 1'b0, 16'($urandom));
        queue_byte(8'd0, 1'b1, 16'hFFFF);
        queue_byte(8'd0, 1'b0, 16'hFFFF);
        queue_byte(8'd0, 1'b0, 16'd0);
        queue_byte(8'd0, 1'b1, 16'd1);
        queue_byte(8'd104, 1'b0, 16'd0);
        queue_byte(8'd97, 1'b0, 16'hFFFF);
        queue_byte(8'd115, 1'b0, 16'h5A5A);
        queue_byte(8'd104, 1'b1, 16'd3);
        for (i = 0; i < 8; i++)
            queue_byte(8'(128 + i), i == 7, 16'hA5A5);
        drain_and_settle();

        // largest primes and full table, no idling
        s_no_idle = 1'b1;
        m_no_idle = 1'b1;
        write_reg(CFG_PRIME_A, 17'd65535);
        write_reg(CFG_PRIME_B, 17'd65535);
        write_reg(CFG_TABLE_SIZE, 17'd65536);
        cfg_valid <= 1'b0;
        for (i = 0; i < 10; i++)
            queue_key(rand_len(), 1'b1);
        drain_and_settle();

        // zero table size acts as one slot; upper data bit dropped on prime writes
        s_no_idle = 1'b0;
        m_no_idle = 1'b0;
        write_reg(CFG_PRIME_A, 17'h1_0097);
        write_reg(CFG_PRIME_B, 17'd2);
        write_reg(CFG_TABLE_SIZE, 17'd0);
        cfg_valid <= 1'b0;
        for (i = 0; i < 5; i++)
            queue_key(rand_len(), 1'b1);
        drain_and_settle();

        // oversized table size saturates
        write_reg(CFG_PRIME_A, 17'd2);
        write_reg(CFG_PRIME_B, 17'd0);
        write_reg(CFG_TABLE_SIZE, 17'h1_FFFF);
        cfg_valid <= 1'b0;
        for (i = 0; i < 5; i++)
            queue_key(rand_len(), 1'b1);
        drain_and_settle();

        // unmapped register write must change nothing
        write_reg(CFG_TABLE_SIZE, 17'd1);
        write_reg(CFG_UNMAPPED, 17'h1_FFFF);
        cfg_valid <= 1'b0;
        for (i = 0; i < 4; i++)
            queue_key(rand_len(), 1'b1);
        drain_and_settle();

        // table resized in the middle of a key
        write_reg(CFG_PRIME_A, 17'd151);
        write_reg(CFG_TABLE_SIZE, 17'd1000);
        cfg_valid <= 1'b0;
        queue_key(4, 1'b0);
        drain_and_settle();
        write_reg(CFG_TABLE_SIZE, 17'd37);
        cfg_valid <= 1'b0;
        queue_key(3, 1'b1);
        drain_and_settle();

        // long output stall while short keys keep coming
        s_no_idle = 1'b1;
        hold_req++;
        for (i = 0; i < 25; i++)
            queue_key(1, 1'b1);
        drain_and_settle();

        rand_start = bytes_queued;
        while (bytes_queued - rand_start < RANDOM_BYTES) begin
            write_reg(CFG_PRIME_A, rand_prime());
            write_reg(CFG_PRIME_B, rand_prime());
            write_reg(CFG_TABLE_SIZE, rand_tsize());
            cfg_valid <= 1'b0;
            s_no_idle = ($urandom_range(0, 3) == 0);
            m_no_idle = ($urandom_range(0, 3) == 0);
            n = bytes_queued + $urandom_range(40, 120);
            while (bytes_queued < n)
                queue_key(rand_len(), 1'b1);
            // sometimes leave a key open across the next setting
            if ($urandom_range(0, 3) == 0)
                queue_key(rand_len(), 1'b0);
            drain_and_settle();
        end

        $display("covered %0d key bytes, %0d slot indexes checked, %0d register writes",
                 bytes_sent, slots_seen, reg_writes);
        $display("settings spanned zero, one, full and oversized tables, mid-key resizing "
                 , "and a long output stall");
        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
